// ===== rtl/utf8_decode_with_cursor_top_assert.svh =====
// assertion macros for the utf8 decoder with cursor
// used by the port checker, no other dependencies
`ifndef UTF8_DECODE_WITH_CURSOR_TOP_ASSERT_SVH
`define UTF8_DECODE_WITH_CURSOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define U8DC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8dc implication check failed");

// antecedent implies consequent in the next cycle
`define U8DC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8dc next-cycle check failed");

`endif

// ===== rtl/u8dc_pkg.sv =====
// shared types, constants and helpers for the utf8 decoder with cursor
// no dependencies
package u8dc_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned CoordOutBits     = 16;
  localparam int unsigned AttrBits         = 16;
  localparam int unsigned CodeBits         = 32;

  localparam logic [15:0] AttrMask  = (AttrBits >= 16) ? 16'hFFFF :
                                      16'((32'd1 << AttrBits) - 32'd1);
  localparam logic [7:0]  NewlineByte = 8'h0A;
  localparam logic [5:0]  ContMask    = 6'h3F;
  localparam logic [7:0]  LeadMask    = 8'hFF;
  localparam int unsigned ContShift   = 6;

  // input word
  typedef struct packed {
    logic [7:0]  text_byte;
    logic [15:0] attr_in;
  } u8dc_in_t;

  // result word
  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [31:0] code_point;
    logic [15:0] attr_out;
  } u8dc_out_t;

  // count of leading ones of a byte, 0 to 8
  function automatic logic [3:0] leading_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      if (run) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/u8dc_in_reg.sv =====
// input register stage of the utf8 decoder
// depends on u8dc_pkg for the input word type
module u8dc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  u8dc_pkg::u8dc_in_t data_i,
  input  logic               ready_i,
  output logic               valid_o,
  output u8dc_pkg::u8dc_in_t data_o
);
  import u8dc_pkg::*;

  logic     valid_q;
  u8dc_in_t data_q;
  logic     accept;
  logic     take;

  // hold the word while the decoder cannot take it
  assign take    = valid_q & ready_i;
  assign stall_o = valid_q & ~ready_i;
  assign accept  = valid_i & ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/u8dc_decode.sv =====
// utf8 sequence decoder and text cursor state
// depends on u8dc_pkg for word types, constants and leading_ones
module u8dc_decode #(
  parameter int unsigned COORD_BITS = u8dc_pkg::CoordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  u8dc_pkg::u8dc_in_t  data_i,
  output logic                emit_o,
  output u8dc_pkg::u8dc_out_t res_o
);
  import u8dc_pkg::*;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [2:0]            pend_q, pend_d;
  logic [CodeBits-1:0]   code_q, code_d;

  logic [7:0]            b;
  logic [3:0]            n_ones;
  logic [7:0]            lead_bits;
  logic                  emit_c;
  logic [CodeBits-1:0]   emit_code;
  logic [31:0]           col_wide;
  logic [31:0]           row_wide;

  assign b         = data_i.text_byte;
  assign n_ones    = leading_ones(b);
  assign lead_bits = b & (LeadMask >> n_ones);

  // next state and result for the byte in the input register
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    code_d    = code_q;
    emit_c    = 1'b0;
    emit_code = code_q;
    if (pend_q != 3'd0) begin
      // continuation, taken whatever its value
      code_d    = (code_q << ContShift) | CodeBits'(b[5:0] & ContMask);
      pend_d    = pend_q - 3'd1;
      emit_c    = (pend_d == 3'd0);
      emit_code = code_d;
    end else if (b == NewlineByte) begin
      col_d = '0;
      row_d = row_q + COORD_BITS'(1);
    end else if (!b[7]) begin
      emit_c    = 1'b1;
      emit_code = CodeBits'(b);
    end else begin
      // lead byte, lone continuation emits at once
      code_d    = CodeBits'(lead_bits);
      emit_code = code_d;
      if (n_ones <= 4'd1) begin
        emit_c = 1'b1;
      end else begin
        pend_d = 3'(n_ones - 4'd1);
      end
    end
    if (emit_c) begin
      col_d = col_q + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
      code_q <= '0;
    end else if (fire_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      code_q <= code_d;
    end
  end

  // result word at the current cursor
  assign col_wide = 32'(col_q);
  assign row_wide = 32'(row_q);

  always_comb begin
    res_o.col        = col_wide[CoordOutBits-1:0];
    res_o.row        = row_wide[CoordOutBits-1:0];
    res_o.code_point = emit_code;
    res_o.attr_out   = data_i.attr_in & AttrMask;
  end

  assign emit_o = fire_i & emit_c;

endmodule

// ===== rtl/u8dc_out_reg.sv =====
// result register with skid stage of the utf8 decoder
// depends on u8dc_pkg for the result word type
module u8dc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u8dc_pkg::u8dc_out_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                stall_i,
  output u8dc_pkg::u8dc_out_t data_o
);
  import u8dc_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  u8dc_out_t out_q;
  u8dc_out_t skid_q;
  logic      pop;

  assign pop     = out_valid_q & ~stall_i;
  assign ready_o = ~skid_valid_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/utf8_decode_with_cursor_top.sv =====
// top level of the utf8 decoder with text cursor
// depends on u8dc_pkg, u8dc_in_reg, u8dc_decode and u8dc_out_reg
//
// usage:
//   input channel valid_i / stall_o / data_i carries one text byte and its
//   attribute word per word; a word is taken when valid_i is high and
//   stall_o is low.
//   output channel valid_o / stall_i / data_o carries one decoded character
//   with its cursor column, row and attribute; it moves when valid_o is high
//   and stall_i is low.
//   an input word goes through the input register and then the result
//   register; one byte is taken every cycle while stall_o is low, with a single
//   decode step between the input register and the result register.
//   newlines and all but the last byte of a multi-byte sequence give no result word.
//   reset clears the cursor to row 0, column 0 and drops any pending
//   sequence and any held words.
//   when the receiver stalls, the result waits in the output register and
//   one more fits in the skid stage; after that stall_o rises and the input
//   word holds in the input register.
module utf8_decode_with_cursor_top #(
  parameter int unsigned COORD_BITS = u8dc_pkg::CoordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  u8dc_pkg::u8dc_in_t  data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output u8dc_pkg::u8dc_out_t data_o
);
  import u8dc_pkg::*;

  logic      in_valid;
  u8dc_in_t  in_word;
  logic      out_ready;
  logic      fire;
  logic      emit;
  u8dc_out_t res;

  // input register
  u8dc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .ready_i (out_ready),
    .valid_o (in_valid),
    .data_o  (in_word)
  );

  assign fire = in_valid & out_ready;

  // decode and cursor
  u8dc_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (in_word),
    .emit_o (emit),
    .res_o  (res)
  );

  // result register with skid
  u8dc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (res),
    .ready_o (out_ready),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

endmodule

// ===== rtl/u8dc_checker.sv =====
// port checker for the utf8 decoder with cursor, bound to the top level
// depends on u8dc_pkg and utf8_decode_with_cursor_top_assert.svh
`include "utf8_decode_with_cursor_top_assert.svh"

module u8dc_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_i,
  input logic                stall_o,
  input u8dc_pkg::u8dc_in_t  data_i,
  input logic                valid_o,
  input logic                stall_i,
  input u8dc_pkg::u8dc_out_t data_o
);
  import u8dc_pkg::*;

  logic in_take;

  assign in_take = valid_i & ~stall_o;

  // a newly valid result word must trace back to an input word taken through the input register and the result register
  `U8DC_ASSERT_IMPLY(a_out_latency, clk_i, rst_ni, $rose(valid_o), $past(in_take, 2))

  // the input side only stalls when it just took a word
  `U8DC_ASSERT_IMPLY(a_stall_after_take, clk_i, rst_ni, $rose(stall_o), $past(in_take))

  // a stalled result word holds
  `U8DC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(data_o))

endmodule

bind utf8_decode_with_cursor_top u8dc_port_checker u_chk (.*);

// ===== tb/u8dc_checker.sv =====
// result checker for the utf8 decoder with cursor: watches both channels,
// predicts each character word from the accepted byte words and compares
// depends on u8dc_pkg
module u8dc_checker #(
  parameter int unsigned COORD_BITS = u8dc_pkg::CoordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic                byte_stall_i,
  input  u8dc_pkg::u8dc_in_t  byte_word_i,
  input  logic                char_valid_i,
  input  logic                char_stall_i,
  input  u8dc_pkg::u8dc_out_t char_word_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);
  import u8dc_pkg::*;

  // decoder state as the text stream has left it
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [2:0]            conts_left;
  logic [31:0]           code_acc;

  u8dc_out_t   expected_chars[$];
  int unsigned mismatch_count = 0;

  function automatic int unsigned count_top_ones(input logic [7:0] b);
    int unsigned k;
    k = 0;
    while (k < 8 && b[7-k]) k++;
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // one byte through the decoder; queues the character it completes, if any
  task automatic decode_text_byte(input u8dc_in_t w);
    u8dc_out_t   ch;
    logic [31:0] code;
    logic        emit_now;
    int unsigned n;
    emit_now = 1'b0;
    code     = '0;
    if (conts_left != 3'd0) begin
      // continuation, whatever its value, newline included
      code_acc   = {code_acc[25:0], w.text_byte[5:0] & ContMask};
      conts_left = conts_left - 3'd1;
      code       = code_acc;
      emit_now   = (conts_left == 3'd0);
    end else if (w.text_byte == NewlineByte) begin
      cursor_x = '0;
      cursor_y = cursor_y + COORD_BITS'(1);
    end else if (!w.text_byte[7]) begin
      code     = {24'd0, w.text_byte};
      emit_now = 1'b1;
    end else begin
      // lead byte; a stray continuation counts as a one-byte sequence
      n        = count_top_ones(w.text_byte);
      code_acc = {24'd0, w.text_byte & (8'hFF >> n)};
      if (n <= 1) begin
        code     = code_acc;
        emit_now = 1'b1;
      end else begin
        conts_left = 3'(n - 1);
      end
    end
    if (emit_now) begin
      ch.col        = 16'(cursor_x);
      ch.row        = 16'(cursor_y);
      ch.code_point = code;
      ch.attr_out   = w.attr_in & AttrMask;
      expected_chars.push_back(ch);
      cursor_x = cursor_x + COORD_BITS'(1);
    end
  endtask

  // compare delivered character words, then predict from accepted byte words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    u8dc_out_t want;
    if (!rst_ni) begin
      cursor_x   = '0;
      cursor_y   = '0;
      conts_left = '0;
      code_acc   = '0;
      expected_chars.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (char_valid_i && !char_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character word (code)",
                          char_word_i.code_point, 32'd0);
        end else begin
          want = expected_chars.pop_front();
          if (char_word_i.col != want.col)
            report_mismatch("col", 32'(char_word_i.col), 32'(want.col));
          if (char_word_i.row != want.row)
            report_mismatch("row", 32'(char_word_i.row), 32'(want.row));
          if (char_word_i.code_point != want.code_point)
            report_mismatch("code_point", char_word_i.code_point, want.code_point);
          if (char_word_i.attr_out != want.attr_out)
            report_mismatch("attr_out", 32'(char_word_i.attr_out),
                            32'(want.attr_out));
        end
      end
      if (byte_valid_i && !byte_stall_i) begin
        decode_text_byte(byte_word_i);
      end
      errors_o  <= mismatch_count;
      pending_o <= expected_chars.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the utf8 decoder bench: clock, reset, byte stimulus, receiver stalls
// and the verdict; depends on u8dc_pkg, u8dc_checker and the decoder rtl
module tb_top;
  import u8dc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 16;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  u8dc_in_t    data_i  = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  u8dc_out_t   data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned error_count;
  int unsigned chars_pending;

  // ascii extremes, newline, two-byte char, stray continuations, newline
  // inside a sequence, seven- and eight-byte leads with code overflow
  logic [7:0] warmup [24] = '{
    8'h00, 8'h7F, 8'h0A, 8'hC3, 8'hA9, 8'h80, 8'hBF, 8'hC2, 8'h0A,
    8'hFE, 8'hBF, 8'h80, 8'hFF, 8'h00, 8'h3F, 8'hC0,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  utf8_decode_with_cursor_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .data_i (data_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .data_o (data_o)
  );

  u8dc_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(valid_i),
    .byte_stall_i(stall_o),
    .byte_word_i (data_i),
    .char_valid_i(valid_o),
    .char_stall_i(stall_i),
    .char_word_i (data_o),
    .errors_o    (error_count),
    .pending_o   (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // nothing moving on either channel for too long ends the run
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one byte word, with random idle cycles before it, held until taken
  task automatic send_byte(input logic [7:0] b, input logic [15:0] attr);
    u8dc_in_t w;
    w.text_byte = b;
    w.attr_in   = attr;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_i  <= w;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
  endtask

  // mostly well-formed characters, plus stray and broken bytes
  task automatic send_random_char();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_byte(NewlineByte, 16'($urandom));
    end else if (pick < 35) begin
      send_byte(8'($urandom_range(0, 127)), 16'($urandom));
    end else if (pick < 85) begin
      n    = (pick < 80) ? $urandom_range(2, 4) : $urandom_range(5, 8);
      lead = 8'(((32'hFF << (8 - n)) & 32'hFF) | ($urandom & (32'hFF >> (n + 1))));
      send_byte(lead, 16'($urandom));
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(9) == 0) begin
          send_byte(8'($urandom), 16'($urandom));
        end else begin
          send_byte(8'h80 | 8'($urandom_range(0, 63)), 16'($urandom));
        end
      end
    end else begin
      send_byte(8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    send_idle_pct = 34;
    recv_idle_pct = 86;
    foreach (warmup[i]) begin
      send_byte(warmup[i], (i % 2 == 0) ? 16'h0000 : 16'hFFFF);
    end
    while (bytes_sent < 340) send_random_char();

    // then the other way round
    send_idle_pct = 86;
    recv_idle_pct = 34;
    while (bytes_sent < 650) send_random_char();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 950) send_random_char();
    valid_i <= 1'b0;

    // drain, then allow for any late stray word
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && chars_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
